FILE: rtl/core/wcts_pkg.sv
`default_nettype none

package wcts_pkg;

	localparam int TEXTURE_SIZE_DEF = 128;

	// quotient bits resolved per divider stage
	localparam int DIV_BITS_PER_STAGE = 4;

	localparam int CFG_DATA_W = 10;

	localparam logic [0:0] REG_SCREEN_WIDTH = 1'b0;
	localparam logic [0:0] REG_VIEW_HEIGHT  = 1'b1;

	localparam logic [9:0] SCREEN_WIDTH_RST = 10'd320;
	localparam logic [8:0] VIEW_HEIGHT_RST  = 9'd160;

	typedef struct packed {
		logic [9:0] screen_x;
		logic [9:0] wall_scale;
		logic [7:0] tile_number;
		logic [6:0] texture_column;
		logic [8:0] span_row;
	} wcts_in_t;

	typedef struct packed {
		logic        pixel_valid;
		logic [18:0] pixel_address;
		logic [7:0]  texel_tile;
		logic [13:0] texel_offset;
	} wcts_out_t;

	// request context carried alongside the divider
	typedef struct packed {
		logic [9:0] screen_x;
		logic [7:0] tile_number;
		logic [6:0] texture_column;
		logic [8:0] span_row;
		logic [7:0] top;
		logic [9:0] skip;
		logic       live;
		logic [9:0] scale;
	} wcts_meta_t;

endpackage

`default_nettype wire

FILE: rtl/core/wall_column_texture_scaler.sv
// A span geometry stage comes first. Throughput: one request per cycle while out_ready
// holds; the step divider is a pipelined long division resolving four quotient bits per
// stage, followed by one multiply stage and an output stage.
// Stalls back up stage by stage, so bubbles are squeezed out before in_ready drops.
// Reset (arst_n low, asynchronous): pipeline emptied, screen_width = 320, view_height = 160.
`default_nettype none

module wall_column_texture_scaler #(
	parameter int TEXTURE_SIZE = wcts_pkg::TEXTURE_SIZE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            cfg_we,
	input  wire logic [0:0]                      cfg_index,
	input  wire logic [wcts_pkg::CFG_DATA_W-1:0] cfg_wdata,

	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire wcts_pkg::wcts_in_t              in_data,

	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output wcts_pkg::wcts_out_t                  out_data
);
	import wcts_pkg::*;

	// step = (TEXTURE_SIZE << 24) / (2*scale) = (TEXTURE_SIZE << 23) / scale
	localparam int DW  = $clog2(TEXTURE_SIZE) + 24;
	localparam int BPS = DIV_BITS_PER_STAGE;
	localparam int ND  = (DW + BPS - 1) / BPS;
	localparam int NS  = ND + 3;
	localparam int PW  = DW + 11;
	localparam logic [DW-1:0] DIVIDEND = DW'(TEXTURE_SIZE) << 23;
	localparam logic [13:0]   TS14     = 14'(TEXTURE_SIZE);

	logic [9:0] screen_width_q;
	logic [8:0] view_height_q;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] vld_in;
	logic [NS-1:0] stage_en;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			view_height_q  <= VIEW_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_SCREEN_WIDTH) begin
				screen_width_q <= cfg_wdata[9:0];
			end
			if (cfg_index == REG_VIEW_HEIGHT) begin
				view_height_q <= cfg_wdata[8:0];
			end
		end
	end

	// handshake: a stage moves when it is empty or the next one moves
	always_comb begin
		stage_en[NS-1] = !vld_q[NS-1] || out_ready;
		for (int i = NS - 2; i >= 0; i--) begin
			stage_en[i] = !vld_q[i] || stage_en[i+1];
		end
	end

	assign vld_in   = {vld_q[NS-2:0], in_valid};
	assign in_ready = stage_en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (stage_en[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	// stage 1: span geometry
	logic [10:0] h_c;
	logic [10:0] vh_c;
	logic        short_c;
	logic [10:0] span_c;
	wcts_meta_t  meta_c;
	wcts_meta_t  meta_s1;

	always_comb begin
		h_c     = {in_data.wall_scale, 1'b0};
		vh_c    = 11'(view_height_q);
		short_c = h_c < vh_c;
		span_c  = short_c ? h_c : vh_c;

		meta_c.screen_x       = in_data.screen_x;
		meta_c.tile_number    = in_data.tile_number;
		meta_c.texture_column = in_data.texture_column;
		meta_c.span_row       = in_data.span_row;
		meta_c.scale          = in_data.wall_scale;
		meta_c.top            = short_c ? 8'((vh_c - h_c) >> 1) : 8'd0;
		meta_c.skip           = short_c ? 10'd0 : 10'((h_c - vh_c) >> 1);
		meta_c.live           = (in_data.wall_scale != 10'd0)
		                        && (11'(in_data.span_row) < span_c);
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			meta_s1 <= meta_c;
		end
	end

	// divider stages
	logic [9:0]    rem_sdiv  [ND];
	logic [DW-1:0] quo_sdiv  [ND];
	wcts_meta_t    meta_sdiv [ND];

	for (genvar g = 0; g < ND; g++) begin : g_div
		logic [9:0]    rem_in;
		logic [DW-1:0] quo_in;
		wcts_meta_t    meta_in;
		logic [10:0]   trial;
		logic [9:0]    rem_c;
		logic [DW-1:0] quo_c;

		if (g == 0) begin : g_first
			assign rem_in  = '0;
			assign quo_in  = '0;
			assign meta_in = meta_s1;
		end else begin : g_next
			assign rem_in  = rem_sdiv[g-1];
			assign quo_in  = quo_sdiv[g-1];
			assign meta_in = meta_sdiv[g-1];
		end

		always_comb begin
			int j;
			rem_c = rem_in;
			quo_c = quo_in;
			trial = '0;
			j     = 0;
			for (int b = 0; b < BPS; b++) begin
				if (g * BPS + b < DW) begin
					j     = DW - 1 - (g * BPS + b);
					trial = {rem_c, DIVIDEND[j]};
					if (trial >= {1'b0, meta_in.scale}) begin
						rem_c = 10'(trial - {1'b0, meta_in.scale});
						quo_c = {quo_c[DW-2:0], 1'b1};
					end else begin
						rem_c = trial[9:0];
						quo_c = {quo_c[DW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (stage_en[g+1]) begin
				rem_sdiv[g]  <= rem_c;
				quo_sdiv[g]  <= quo_c;
				meta_sdiv[g] <= meta_in;
			end
		end
	end

	// multiply stage: texel position and framebuffer row offset
	logic [10:0]   tex_row_c;
	logic [9:0]    fb_row_c;
	logic [PW-1:0] idx_prod_s2;
	logic [19:0]   addr_prod_s2;
	wcts_meta_t    meta_s2;

	assign tex_row_c = 11'(meta_sdiv[ND-1].skip) + 11'(meta_sdiv[ND-1].span_row);
	assign fb_row_c  = 10'(meta_sdiv[ND-1].top) + 10'(meta_sdiv[ND-1].span_row);

	always_ff @(posedge clk) begin
		if (stage_en[ND+1]) begin
			idx_prod_s2  <= PW'(tex_row_c) * PW'(quo_sdiv[ND-1]);
			addr_prod_s2 <= 20'(fb_row_c) * 20'(screen_width_q);
			meta_s2      <= meta_sdiv[ND-1];
		end
	end

	// output stage
	wcts_out_t out_c;
	wcts_out_t out_s3;

	always_comb begin
		out_c = '0;
		if (meta_s2.live) begin
			out_c.pixel_valid   = 1'b1;
			out_c.pixel_address = 19'(addr_prod_s2 + 20'(meta_s2.screen_x));
			out_c.texel_tile    = meta_s2.tile_number;
			out_c.texel_offset  = 14'(14'(meta_s2.texture_column) * TS14)
			                      + idx_prod_s2[24 +: 14];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[NS-1]) begin
			out_s3 <= out_c;
		end
	end

	assign out_valid = vld_q[NS-1];
	assign out_data  = out_s3;

	// checks
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.pixel_valid |->
			out_data.pixel_address == 19'd0 && out_data.texel_tile == 8'd0
			&& out_data.texel_offset == 14'd0)
		else $error("invalid pixel carries nonzero fields");

	a_empty_tail_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NS-1] |-> in_ready)
		else $error("input stalled with empty output stage");

	a_zero_scale_dead: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[0] && meta_s1.scale == 10'd0 |-> !meta_s1.live)
		else $error("zero scale request marked drawable");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import wcts_pkg::*;

	localparam int unsigned TEX_SIZE    = TEXTURE_SIZE_DEF;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned PHASE_ITEMS = 305;
	localparam int unsigned DRAIN_WAIT  = 16;

	class texel_scoreboard;
		wcts_out_t   expected_q[$];
		logic [9:0]  pitch;
		logic [8:0]  view_rows;
		int unsigned mismatches;
		int unsigned checked;
		int unsigned drawn;
		int unsigned requests;

		function new();
			pitch      = SCREEN_WIDTH_RST;
			view_rows  = VIEW_HEIGHT_RST;
			mismatches = 0;
			checked    = 0;
			drawn      = 0;
			requests   = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_SCREEN_WIDTH)
				pitch = val;
			else
				view_rows = val[8:0];
		endfunction

		// closed form of the texture stepping loop for one span row
		function wcts_out_t scale_pixel(wcts_in_t r);
			longint unsigned h, step, top, offset, span, idx, k;
			wcts_out_t p;
			p = '0;
			if (r.wall_scale == 0)
				return p;
			k    = r.span_row;
			h    = longint'(r.wall_scale) * 2;
			step = (longint'(TEX_SIZE) << 24) / h;
			if (h < view_rows) begin
				span   = h;
				top    = (view_rows - h) / 2;
				offset = 0;
			end else begin
				span   = view_rows;
				top    = 0;
				offset = ((h - view_rows) / 2) * step;
			end
			if (k >= span)
				return p;
			idx = (offset + k * step) >> 24;
			p.pixel_valid   = 1'b1;
			p.pixel_address = 19'((top + k) * pitch + r.screen_x);
			p.texel_tile    = r.tile_number;
			p.texel_offset  = 14'(longint'(r.texture_column) * TEX_SIZE + idx);
			return p;
		endfunction

		function void note_request(wcts_in_t r);
			expected_q.push_back(scale_pixel(r));
			requests++;
		endfunction

		function void check_pixel(wcts_out_t got);
			wcts_out_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: result with nothing pending: %p", got);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.pixel_valid)
				drawn++;
			if (got.pixel_valid !== want.pixel_valid ||
			    got.pixel_address !== want.pixel_address ||
			    got.texel_tile !== want.texel_tile ||
			    got.texel_offset !== want.texel_offset) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: result %0d: expected v=%0d addr=%0d tile=%0d off=%0d, got v=%0d addr=%0d tile=%0d off=%0d",
						checked, want.pixel_valid, want.pixel_address, want.texel_tile,
						want.texel_offset, got.pixel_valid, got.pixel_address,
						got.texel_tile, got.texel_offset);
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [0:0]            cfg_index = REG_SCREEN_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	wcts_in_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	wcts_out_t             out_data;

	int unsigned send_idle_pct = 19;
	int unsigned recv_idle_pct = 61;
	int unsigned settings_used = 1;

	texel_scoreboard sb = new();

	wall_column_texture_scaler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// requests are noted before results at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(in_data);
			if (out_valid && out_ready)
				sb.check_pixel(out_data);
		end
	end

	function automatic wcts_in_t mk(int unsigned x, int unsigned scale, int unsigned tile,
			int unsigned col, int unsigned k);
		wcts_in_t r;
		r.screen_x       = 10'(x);
		r.wall_scale     = 10'(scale);
		r.tile_number    = 8'(tile);
		r.texture_column = 7'(col);
		r.span_row       = 9'(k);
		return r;
	endfunction

	// biased toward rows inside the span so most requests draw a pixel
	function automatic wcts_in_t random_request();
		int unsigned scale, span, mode, k, hi;
		mode = $urandom_range(9);
		if (mode == 0)
			scale = 0;
		else if (mode <= 2)
			scale = $urandom_range(1023);
		else begin
			hi = sb.view_rows / 2 + 8;
			if (hi > 1023)
				hi = 1023;
			scale = $urandom_range(hi, 1);
		end
		if (scale == 0)
			span = 0;
		else if (2 * scale < sb.view_rows)
			span = 2 * scale;
		else
			span = sb.view_rows;
		if (span > 0 && $urandom_range(3) != 0)
			k = $urandom_range(span - 1);
		else
			k = $urandom_range(511);
		return mk($urandom_range(1023), scale, $urandom_range(255), $urandom_range(127), k);
	endfunction

	task automatic send_request(input wcts_in_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// one edge first so the last accepted request is already noted
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int pitch_set[6];
		int rows_set[6];
		int unsigned ph, i;
		logic [CFG_DATA_W-1:0] wv, hv;

		pitch_set = '{640, 1, 0, 1023, -1, 320};
		rows_set  = '{480, 1, 0, 'h3FF, -1, 160};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, pitch 320, view 160
		send_request(mk(0, 0, 0, 0, 0));
		send_request(mk(639, 0, 255, 127, 511));
		send_request(mk(0, 1, 0, 0, 0));
		send_request(mk(5, 1, 1, 1, 1));
		send_request(mk(5, 1, 1, 1, 2));
		send_request(mk(100, 79, 7, 3, 0));
		send_request(mk(100, 79, 7, 3, 157));
		send_request(mk(100, 79, 7, 3, 158));
		send_request(mk(100, 80, 9, 4, 0));
		send_request(mk(100, 80, 9, 4, 159));
		send_request(mk(100, 80, 9, 4, 160));
		send_request(mk(1023, 1023, 255, 127, 0));
		send_request(mk(1023, 1023, 255, 127, 159));
		send_request(mk(639, 1023, 128, 64, 511));
		send_request(mk(0, 512, 85, 42, 80));
		send_request(mk(1023, 200, 170, 85, 100));
		send_request(mk(319, 81, 0, 127, 159));
		send_request(mk(512, 40, 255, 0, 40));
		send_request(mk(1, 1023, 1, 126, 1));
		send_request(mk(638, 300, 254, 1, 158));

		for (ph = 0; ph < 6; ph++) begin
			drain();
			wv = (pitch_set[ph] < 0) ? CFG_DATA_W'($urandom_range(1023)) :
				CFG_DATA_W'(pitch_set[ph]);
			hv = (rows_set[ph] < 0) ? CFG_DATA_W'($urandom_range(1023)) :
				CFG_DATA_W'(rows_set[ph]);
			write_reg(REG_SCREEN_WIDTH, wv);
			write_reg(REG_VIEW_HEIGHT, hv);
			cfg_we <= 1'b0;
			settings_used++;
			if (ph < 2) begin
				send_idle_pct = 19;
				recv_idle_pct = 61;
			end else if (ph < 4) begin
				send_idle_pct = 61;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (i = 0; i < PHASE_ITEMS; i++)
				send_request(random_request());
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d requests across %0d register settings, pitch 0..1023, view 0..511",
			sb.requests, settings_used);
		$display("Checked %0d results, %0d of them drawn pixels", sb.checked, sb.drawn);
		if (sb.pending() != 0)
			$display("ERROR: %0d expected results never arrived", sb.pending());
		if (sb.mismatches > MAX_REPORTS)
			$display("%0d mismatches in total", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#400_000;
		$display("ERROR: timeout with %0d results pending", sb.pending());
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/wcts_pkg.sv
rtl/core/wall_column_texture_scaler.sv
tb/sv/tb_top.sv
